// ----- hw/rtl/lte_pkg.sv -----
`default_nettype none

package lte_pkg;

    // Default edge length of the square grid
    localparam int GRID_SIZE_DEF = 64;

    // Item field widths
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 6;
    localparam int CNT_W    = 4;
    localparam int POS_SPAN = 2 ** POS_W;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_TOGGLE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_STEP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd3;

    // Conway rule thresholds
    localparam logic [CNT_W-1:0] SURVIVE_MIN = 4'd2;
    localparam logic [CNT_W-1:0] BIRTH_CNT   = 4'd3;

endpackage

`default_nettype wire

// ----- hw/rtl/life_torus_generation_engine.sv -----
// Toroidal Game of Life engine.
// Input channel: in_valid / in_stall with func, pos_x, pos_y. An item is taken
// when in_valid is high and in_stall is low. func selects toggle, clear,
// advance one generation, or read of the cell at (pos_x, pos_y); positions
// wrap modulo GRID_SIZE.
// Output channel: out_valid / out_stall with cell_alive and neighbor_count,
// one result item per input item, describing the addressed cell after the
// operation. Results come out in input order.
// Toggle, clear and read go straight to the report pass. A generation step
// sweeps the grid first: the row memory is read once per cycle, three rows to
// prime the window and one row per cycle during the sweep, with the row unit
// rewriting each row in place, then the report pass reads three rows.
// in_stall stays high while an item is in flight, so one item is handled at a
// time. The result sits in an output register; the engine returns to idle and
// takes the next item while that result waits. If the receiver still stalls
// when the next result is ready, the engine holds until the slot frees.
// Reset clears every cell to dead at once through per-row valid bits, with no
// clearing pass; the engine is ready as soon as reset is released.
`default_nettype none

module life_torus_generation_engine #(
    parameter int GRID_SIZE = lte_pkg::GRID_SIZE_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [lte_pkg::FUNC_W-1:0]  func,
    input  wire logic [lte_pkg::POS_W-1:0]   pos_x,
    input  wire logic [lte_pkg::POS_W-1:0]   pos_y,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             cell_alive,
    output logic      [lte_pkg::CNT_W-1:0]   neighbor_count
);

    localparam int IDX_W = $clog2(GRID_SIZE);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PRE0   = 4'd1;
    localparam logic [3:0] ST_PRE1   = 4'd2;
    localparam logic [3:0] ST_PRE2   = 4'd3;
    localparam logic [3:0] ST_SWEEP  = 4'd4;
    localparam logic [3:0] ST_RD_UP  = 4'd5;
    localparam logic [3:0] ST_RD_CUR = 4'd6;
    localparam logic [3:0] ST_RD_DN  = 4'd7;
    localparam logic [3:0] ST_CNT    = 4'd8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

    // Coordinate reduction table, worked out at elaboration
    function automatic logic [lte_pkg::POS_SPAN-1:0][IDX_W-1:0] build_wrap_lut();
        logic [lte_pkg::POS_SPAN-1:0][IDX_W-1:0] lut;
        for (int i = 0; i < lte_pkg::POS_SPAN; i++)
        begin
            lut[i] = IDX_W'(i % GRID_SIZE);
        end
        return lut;
    endfunction

    localparam logic [lte_pkg::POS_SPAN-1:0][IDX_W-1:0] WRAP_LUT = build_wrap_lut();

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    logic [3:0]                  state_reg, state_next;
    logic [IDX_W-1:0]            row_reg, row_next;
    logic [IDX_W-1:0]            px_reg, py_reg;
    logic [lte_pkg::FUNC_W-1:0]  func_reg;

    // Row window: old row above, old current row, old row 0
    logic [GRID_SIZE-1:0]        above_reg, cur_reg, row0_reg;

    logic                        out_valid_reg;
    logic                        cell_alive_reg;
    logic [lte_pkg::CNT_W-1:0]   count_reg;

    logic                        in_accept;
    logic                        out_load;
    logic                        slot_free;

    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [GRID_SIZE-1:0]        wr_data;
    logic [IDX_W-1:0]            rd_addr;
    logic [GRID_SIZE-1:0]        rd_data;

    logic [GRID_SIZE-1:0]        below_sel;
    logic [GRID_SIZE-1:0]        next_row;
    logic [GRID_SIZE-1:0][lte_pkg::CNT_W-1:0] counts;
    logic [GRID_SIZE-1:0]        cell_mask;
    logic [GRID_SIZE-1:0]        edited_row;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_CNT) && slot_free;

    assign out_valid      = out_valid_reg;
    assign cell_alive     = cell_alive_reg;
    assign neighbor_count = count_reg;

    lte_grid_mem #(
        .GRID_SIZE (GRID_SIZE)
    ) u_grid_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // On the last row of a sweep the row below is the saved old row 0
    assign below_sel = ((state_reg == ST_SWEEP) && (row_reg == LAST_IDX)) ? row0_reg : rd_data;

    lte_row_unit #(
        .GRID_SIZE (GRID_SIZE)
    ) u_row_unit (
        .above    (above_reg),
        .cur      (cur_reg),
        .below    (below_sel),
        .next_row (next_row),
        .counts   (counts)
    );

    // Apply toggle or clear to the addressed row as it arrives
    assign cell_mask = GRID_SIZE'(1) << px_reg;

    always_comb
    begin
        unique case (func_reg)
            lte_pkg::FUNC_TOGGLE: edited_row = rd_data ^ cell_mask;
            lte_pkg::FUNC_CLEAR:  edited_row = rd_data & ~cell_mask;
            default:              edited_row = rd_data;
        endcase
    end

    // Memory port control
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = row_reg;
        wr_data = next_row;
        rd_addr = py_reg;
        unique case (state_reg)
            ST_PRE0:   rd_addr = LAST_IDX;
            ST_PRE1:   rd_addr = '0;
            ST_PRE2:   rd_addr = wrap_next('0);
            ST_SWEEP:
            begin
                rd_addr = wrap_next(wrap_next(row_reg));
                wr_en   = 1'b1;
            end
            ST_RD_UP:  rd_addr = wrap_prev(py_reg);
            ST_RD_CUR: rd_addr = py_reg;
            ST_RD_DN:
            begin
                rd_addr = wrap_next(py_reg);
                wr_en   = (func_reg == lte_pkg::FUNC_TOGGLE) || (func_reg == lte_pkg::FUNC_CLEAR);
                wr_addr = py_reg;
                wr_data = edited_row;
            end
            // Hold the row below in view while the result waits for the slot
            ST_CNT:    rd_addr = wrap_next(py_reg);
            default:   rd_addr = py_reg;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (func == lte_pkg::FUNC_STEP) ? ST_PRE0 : ST_RD_UP;
                end
            end
            ST_PRE0:   state_next = ST_PRE1;
            ST_PRE1:   state_next = ST_PRE2;
            ST_PRE2:
            begin
                state_next = ST_SWEEP;
                row_next   = '0;
            end
            ST_SWEEP:
            begin
                row_next = wrap_next(row_reg);
                if (row_reg == LAST_IDX)
                begin
                    state_next = ST_RD_UP;
                end
            end
            ST_RD_UP:  state_next = ST_RD_CUR;
            ST_RD_CUR: state_next = ST_RD_DN;
            ST_RD_DN:  state_next = ST_CNT;
            ST_CNT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            func_reg <= func;
            px_reg   <= WRAP_LUT[pos_x];
            py_reg   <= WRAP_LUT[pos_y];
        end

        unique case (state_reg)
            ST_PRE1:   above_reg <= rd_data;
            ST_PRE2:
            begin
                cur_reg  <= rd_data;
                row0_reg <= rd_data;
            end
            ST_SWEEP:
            begin
                above_reg <= cur_reg;
                cur_reg   <= below_sel;
            end
            ST_RD_CUR: above_reg <= rd_data;
            ST_RD_DN:  cur_reg   <= edited_row;
            default:
            begin
                // hold the window
            end
        endcase

        if (out_load)
        begin
            cell_alive_reg <= cur_reg[px_reg];
            count_reg      <= counts[px_reg];
        end
    end

`ifndef SYNTH
    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("engine did not go busy after taking an item");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == ST_SWEEP) || (state_reg == ST_RD_DN)))
        else $error("grid written outside sweep or edit");

    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || !out_stall))
        else $error("result overwrote a stalled result");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg <= lte_pkg::CNT_W'(8)))
        else $error("neighbor count above eight");

    a_sweep_ends_in_report: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SWEEP) && (row_reg == LAST_IDX)) |=> (state_reg == ST_RD_UP))
        else $error("sweep did not hand over to the report pass");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/lte_grid_mem.sv -----
`default_nettype none

module lte_grid_mem #(
    parameter int GRID_SIZE = lte_pkg::GRID_SIZE_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         wr_en,
    input  wire logic [$clog2(GRID_SIZE)-1:0] wr_addr,
    input  wire logic [GRID_SIZE-1:0]         wr_data,
    input  wire logic [$clog2(GRID_SIZE)-1:0] rd_addr,
    output logic      [GRID_SIZE-1:0]         rd_data
);

    logic [GRID_SIZE-1:0] mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] row_valid_reg;
    logic [GRID_SIZE-1:0] mem_q_reg;
    logic                 vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Rows never written read as all dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            vld_q_reg     <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= row_valid_reg[rd_addr];
        end
    end

    assign rd_data = vld_q_reg ? mem_q_reg : '0;

endmodule

`default_nettype wire

// ----- hw/rtl/lte_row_unit.sv -----
`default_nettype none

module lte_row_unit #(
    parameter int GRID_SIZE = lte_pkg::GRID_SIZE_DEF
) (
    input  wire logic [GRID_SIZE-1:0]                     above,
    input  wire logic [GRID_SIZE-1:0]                     cur,
    input  wire logic [GRID_SIZE-1:0]                     below,
    output logic      [GRID_SIZE-1:0]                     next_row,
    output logic      [GRID_SIZE-1:0][lte_pkg::CNT_W-1:0] counts
);

    for (genvar c = 0; c < GRID_SIZE; c++)
    begin : g_lane
        localparam int L = (c == 0) ? GRID_SIZE - 1 : c - 1;
        localparam int R = (c == GRID_SIZE - 1) ? 0 : c + 1;

        assign counts[c] = lte_pkg::CNT_W'(above[L]) + lte_pkg::CNT_W'(above[c])
                         + lte_pkg::CNT_W'(above[R]) + lte_pkg::CNT_W'(cur[L])
                         + lte_pkg::CNT_W'(cur[R])   + lte_pkg::CNT_W'(below[L])
                         + lte_pkg::CNT_W'(below[c]) + lte_pkg::CNT_W'(below[R]);

        // Survive on two or three, birth on exactly three
        assign next_row[c] = (counts[c] == lte_pkg::BIRTH_CNT)
                           || (cur[c] && (counts[c] == lte_pkg::SURVIVE_MIN));
    end

endmodule

`default_nettype wire

// ----- tb/tb_life_torus_generation_engine.sv -----
module tb_life_torus_generation_engine;
    timeunit 1ns;
    timeprecision 1ps;

    // Grid edge as built, and the run's pacing
    localparam int SIDE          = lte_pkg::GRID_SIZE_DEF;
    localparam logic [lte_pkg::POS_W-1:0] LAST = lte_pkg::POS_W'(lte_pkg::POS_SPAN - 1);
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = SIDE + 24;
    localparam int COLONY_ITEMS  = 1340;
    localparam int STEADY_ITEMS  = 110;

    // One expected result, with the item that caused it for the log
    typedef struct {
        logic [lte_pkg::FUNC_W-1:0] op;
        logic [lte_pkg::POS_W-1:0]  x;
        logic [lte_pkg::POS_W-1:0]  y;
        logic                       alive;
        logic [lte_pkg::CNT_W-1:0]  count;
    } cell_report_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [lte_pkg::FUNC_W-1:0] func      = lte_pkg::FUNC_READ;
    logic [lte_pkg::POS_W-1:0]  pos_x     = '0;
    logic [lte_pkg::POS_W-1:0]  pos_y     = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       cell_alive;
    logic [lte_pkg::CNT_W-1:0]  neighbor_count;

    // Predicted grid: colony[y][x], all dead after reset
    logic [SIDE-1:0] colony [SIDE] = '{default: '0};

    // Expected results in item order
    cell_report_t pending_reports [$];

    int  mismatches    = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  cycle_count   = 0;
    int  op_tally [4]  = '{default: 0};
    bit  calm          = 1'b0;  // no idling on either side
    bit  hold_request  = 1'b0;  // ask the receiver for one long hold
    bit  hold_active   = 1'b0;

    life_torus_generation_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cell_alive     (cell_alive),
        .neighbor_count (neighbor_count)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Count live cells among the eight wrapped neighbors of (x, y).
    function automatic int unsigned live_neighbors(int x, int y);
        int unsigned total;
        total = 0;
        for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++)
                if (dx != 0 || dy != 0)
                    total += colony[(y + dy + SIDE) % SIDE][(x + dx + SIDE) % SIDE];
        return total;
    endfunction

    // Replace the grid with its next generation. Every cell sees the old
    // generation, which is what the in-place sweep with its row window yields.
    function automatic void advance_colony();
        logic [SIDE-1:0] next_rows [SIDE];
        int unsigned n;
        for (int y = 0; y < SIDE; y++)
            for (int x = 0; x < SIDE; x++)
            begin
                n = live_neighbors(x, y);
                if (colony[y][x])
                    next_rows[y][x] = (n == lte_pkg::SURVIVE_MIN) || (n == lte_pkg::BIRTH_CNT);
                else
                    next_rows[y][x] = (n == lte_pkg::BIRTH_CNT);
            end
        colony = next_rows;
    endfunction

    // Apply one item to the predicted grid and report the addressed cell.
    function automatic cell_report_t predict_cell(logic [lte_pkg::FUNC_W-1:0] op,
                                                  logic [lte_pkg::POS_W-1:0] px,
                                                  logic [lte_pkg::POS_W-1:0] py);
        cell_report_t r;
        int x;
        int y;
        x = px % SIDE;
        y = py % SIDE;
        case (op)
            lte_pkg::FUNC_TOGGLE: colony[y][x] = ~colony[y][x];
            lte_pkg::FUNC_CLEAR:  colony[y][x] = 1'b0;
            lte_pkg::FUNC_STEP:   advance_colony();
            default:              ;
        endcase
        r.op    = op;
        r.x     = px;
        r.y     = py;
        r.alive = colony[y][x];
        r.count = lte_pkg::CNT_W'(live_neighbors(x, y));
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item per call, with random idle bursts ahead of it
    // ------------------------------------------------------------------
    task automatic send_item(input logic [lte_pkg::FUNC_W-1:0] op,
                             input logic [lte_pkg::POS_W-1:0] px,
                             input logic [lte_pkg::POS_W-1:0] py);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        pos_x    <= px;
        pos_y    <= py;
        // Hold the payload until the block takes it.
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_reports.push_back(predict_cell(op, px, py));
        op_tally[op]++;
        items_sent++;
    endtask

    // Offset a coordinate by up to +/- span, wrapping at the field width.
    function automatic logic [lte_pkg::POS_W-1:0] jitter_pos(logic [lte_pkg::POS_W-1:0] c,
                                                             int span);
        return lte_pkg::POS_W'(int'(c) + $urandom_range(0, 2 * span) - span);
    endfunction

    // Draw a coordinate anywhere in the field range.
    function automatic logic [lte_pkg::POS_W-1:0] any_pos();
        return lte_pkg::POS_W'($urandom_range(0, LAST));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold on request
    // ------------------------------------------------------------------
    initial
    begin
        int span;
        int held;
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                out_stall   <= 1'b1;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_active = 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                span = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want,
                                   input cell_report_t ctx);
        // Keep the log short if everything goes wrong; count every one.
        if (mismatches < 30)
            $display("MISMATCH %s: got %0d, expected %0d (op %0d at x=%0d y=%0d)",
                     what, got, want, ctx.op, ctx.x, ctx.y);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cell_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                want = '{op: lte_pkg::FUNC_READ, x: '0, y: '0, alive: 1'b0, count: '0};
                report_mismatch("result with nothing outstanding", cell_alive, 0, want);
            end
            else
            begin
                want = pending_reports.pop_front();
                results_seen++;
                if (cell_alive !== want.alive)
                    report_mismatch("cell_alive", cell_alive, want.alive, want);
                if (neighbor_count !== want.count)
                    report_mismatch("neighbor_count", neighbor_count, want.count, want);
            end
        end
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_reports.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Fill all eight neighbors of the origin across both wrap edges.
    task automatic test_wrap_neighborhood();
        send_item(lte_pkg::FUNC_STEP,   0, 0);          // empty grid stays empty
        send_item(lte_pkg::FUNC_TOGGLE, LAST, LAST);
        send_item(lte_pkg::FUNC_TOGGLE, 0, LAST);
        send_item(lte_pkg::FUNC_TOGGLE, 1, LAST);
        send_item(lte_pkg::FUNC_TOGGLE, LAST, 0);
        send_item(lte_pkg::FUNC_TOGGLE, 1, 0);
        send_item(lte_pkg::FUNC_TOGGLE, LAST, 1);
        send_item(lte_pkg::FUNC_TOGGLE, 0, 1);
        send_item(lte_pkg::FUNC_TOGGLE, 1, 1);
        send_item(lte_pkg::FUNC_READ,   0, 0);          // dead with a full ring
        send_item(lte_pkg::FUNC_STEP,   LAST, LAST);
        send_item(lte_pkg::FUNC_CLEAR,  0, 0);
    endtask

    // Toggle twice, clear live and dead cells, and run a blinker over the
    // left/right seam.
    task automatic test_toggle_clear_blinker();
        send_item(lte_pkg::FUNC_TOGGLE, 20, LAST);
        send_item(lte_pkg::FUNC_TOGGLE, 20, LAST);
        send_item(lte_pkg::FUNC_TOGGLE, LAST, 40);
        send_item(lte_pkg::FUNC_CLEAR,  LAST, 40);
        send_item(lte_pkg::FUNC_CLEAR,  LAST, 40);
        send_item(lte_pkg::FUNC_TOGGLE, LAST, 32);
        send_item(lte_pkg::FUNC_TOGGLE, 0, 32);
        send_item(lte_pkg::FUNC_TOGGLE, 1, 32);
        send_item(lte_pkg::FUNC_STEP,   0, 32);
        send_item(lte_pkg::FUNC_READ,   0, 31);
        send_item(lte_pkg::FUNC_STEP,   LAST, 32);
        send_item(lte_pkg::FUNC_READ,   0, 33);
    endtask

    // Hold the output for a long stretch while items keep coming, so the
    // result register fills and the block stalls its input.
    task automatic test_output_hold();
        hold_request = 1'b1;
        wait (hold_active);
        for (int i = 0; i < 14; i++)
        begin
            if (i % 5 == 2)
                send_item(lte_pkg::FUNC_STEP, any_pos(), any_pos());
            else
                send_item(lte_pkg::FUNC_TOGGLE, jitter_pos(10, 2), jitter_pos(50, 2));
        end
    endtask

    // Seed small random colonies, evolve them and probe around them, with
    // fully random items mixed in.
    task automatic test_random_colonies(input int target);
        logic [lte_pkg::POS_W-1:0] cx;
        logic [lte_pkg::POS_W-1:0] cy;
        int seeds;
        int gens;
        int looks;
        while (items_sent < target)
        begin
            cx    = any_pos();
            cy    = any_pos();
            seeds = $urandom_range(3, 14);
            repeat (seeds)
                send_item(lte_pkg::FUNC_TOGGLE, jitter_pos(cx, 2), jitter_pos(cy, 2));
            gens = $urandom_range(1, 4);
            repeat (gens)
            begin
                send_item(lte_pkg::FUNC_STEP, jitter_pos(cx, 3), jitter_pos(cy, 3));
                looks = $urandom_range(0, 3);
                repeat (looks)
                    send_item(lte_pkg::FUNC_READ, jitter_pos(cx, 4), jitter_pos(cy, 4));
            end
            if ($urandom_range(0, 2) == 0)
                send_item(lte_pkg::FUNC_CLEAR, jitter_pos(cx, 2), jitter_pos(cy, 2));
            if ($urandom_range(0, 1) == 0)
                send_item(lte_pkg::FUNC_W'($urandom_range(0, (1 << lte_pkg::FUNC_W) - 1)),
                          any_pos(), any_pos());
        end
    endtask

    // Same traffic with both sides always ready.
    task automatic test_steady_stream();
        calm = 1'b1;
        test_random_colonies(items_sent + STEADY_ITEMS);
    endtask

    initial
    begin
        // Reset once, then release at a clock edge.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_wrap_neighborhood();
        test_toggle_clear_blinker();
        test_output_hold();
        test_random_colonies(COLONY_ITEMS);
        test_steady_stream();
        in_valid <= 1'b0;

        // Drain, then watch a while for stray results.
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d items: %0d toggles, %0d clears, %0d generation steps, %0d reads",
                 items_sent, op_tally[lte_pkg::FUNC_TOGGLE], op_tally[lte_pkg::FUNC_CLEAR],
                 op_tally[lte_pkg::FUNC_STEP], op_tally[lte_pkg::FUNC_READ]);
        $display("Checked %0d results over wrap edges, seeded colonies and a long output hold",
                 results_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
